[src/base58_encoder_assert.svh]
// Assertion macros shared by the base58 encoder RTL.
`ifndef BASE58_ENCODER_ASSERT_SVH
`define BASE58_ENCODER_ASSERT_SVH

// Condition that holds at every clock edge out of reset
`define B58_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication
`define B58_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define B58_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/b58enc_pkg.sv]
// Package: sizes, sequencer states and alphabet lookup for the base58 encoder.
`timescale 1ns / 1ps

package b58enc_pkg;

    localparam int MAX_BYTES  = 32;
    localparam int MAX_DIGITS = 45;

    // Widths of counters and indexes
    localparam int DIG_W  = 6;                          // one base-58 digit
    localparam int DIG_AW = $clog2(MAX_DIGITS);         // digit store address
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);     // digit count
    localparam int BYTE_W = $clog2(MAX_BYTES + 1);      // byte and zero-run counts

    // Divide-by-58 unit: x = digit * 256 + carry stays below 2^14
    localparam int X_W      = 14;
    localparam int Q_W      = 8;
    localparam int RECIP_W  = 15;
    localparam int RECIP_SH = 20;
    localparam int PROD_W   = X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_58 = 15'd18079;   // ceil(2^20 / 58)

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_EXT,
        ST_EMIT_ONE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } b58_state_t;

    // Map a base-58 digit to its character; codes past 57 give '1'
    function automatic logic [7:0] b58_char(input logic [DIG_W-1:0] d);
        logic [7:0] d8;
        d8 = {2'b00, d};
        case (d) inside
            [6'd0:6'd8]:   b58_char = 8'h31 + d8;           // 1..9
            [6'd9:6'd16]:  b58_char = 8'h41 + d8 - 8'd9;    // A..H
            [6'd17:6'd21]: b58_char = 8'h4A + d8 - 8'd17;   // J..N
            [6'd22:6'd32]: b58_char = 8'h50 + d8 - 8'd22;   // P..Z
            [6'd33:6'd43]: b58_char = 8'h61 + d8 - 8'd33;   // a..k
            [6'd44:6'd57]: b58_char = 8'h6D + d8 - 8'd44;   // m..z
            default:       b58_char = 8'h31;
        endcase
    endfunction

endpackage

[src/b58enc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module b58enc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/b58enc_div58.sv]
// Shared divide-by-58 unit: quotient by reciprocal multiply, remainder by shift-add.
`timescale 1ns / 1ps

module b58enc_div58
    import b58enc_pkg::*;
(
    input  logic [X_W-1:0]   x,
    output logic [Q_W-1:0]   quot,
    output logic [DIG_W-1:0] rem
);

    logic [PROD_W-1:0] prod;
    logic [X_W-1:0]    q58;
    logic [X_W-1:0]    rem_full;

    // Reciprocal is exact for every x below 2^14
    assign prod = PROD_W'(x) * PROD_W'(RECIP_58);
    assign quot = prod[RECIP_SH +: Q_W];

    // 58 = 32 + 16 + 8 + 2
    assign q58 = X_W'({quot, 5'b0}) + X_W'({quot, 4'b0})
               + X_W'({quot, 3'b0}) + X_W'({quot, 1'b0});
    assign rem_full = x - q58;
    assign rem      = rem_full[DIG_W-1:0];

endmodule

[src/base58_encoder.sv]
// Top level: streaming base58 encoder with the Bitcoin alphabet.
`timescale 1ns / 1ps
`include "base58_encoder_assert.svh"

// Usage
//   Input stream: one message byte per item on s_axis_tdata, most significant
//   byte first, s_axis_tlast on the final byte. Output stream: one ASCII
//   character per item on m_axis_tdata, most significant first, m_axis_tlast on
//   the final character, m_axis_tuser set on every character of a message whose
//   bytes past 32 were dropped.
//   Each byte that is kept runs through the digit store one digit per cycle
//   using a single divide-by-58 unit: a fold over the D digits held before
//   the byte (D up to 45), then an extension that grows new digits while carry
//   is left, and a closing step. s_axis_tready is low for that whole time.
//   After the final byte the text comes out: each leading '1', then each digit
//   as a store read followed by an output load. A stall simply holds the output
//   register and the emission sequence; a new message byte may be accepted
//   while the last character still waits to be taken.
//   Reset (aresetn low, synchronous) empties the message and the output; no
//   clearing pass is needed, the first byte of a message ignores the store.

module base58_encoder
    import b58enc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_char
    output logic       m_axis_tlast,
    output logic [0:0] m_axis_tuser     // [0] overflow
);

    b58_state_t state_reg, state_next;

    logic [Q_W-1:0]    carry_reg, carry_next;
    logic [DIG_AW-1:0] j_reg, j_next;
    logic [CNT_W-1:0]  digit_count_reg, digit_count_next;
    logic [BYTE_W-1:0] zero_run_reg, zero_run_next;
    logic              all_zero_reg, all_zero_next;
    logic [BYTE_W-1:0] byte_count_reg, byte_count_next;
    logic              ovf_reg, ovf_next;
    logic              last_pend_reg, last_pend_next;
    logic              fresh_reg, fresh_next;
    logic [BYTE_W-1:0] ones_reg, ones_next;
    logic [DIG_AW-1:0] dig_idx_reg, dig_idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_user_reg, m_user_next;

    logic              accept;
    logic              room;
    logic              fold_end;
    logic              ext_done;
    logic              out_free;
    logic [BYTE_W-1:0] ones_calc;
    b58_state_t        emit_state;

    logic              ram_we;
    logic [DIG_AW-1:0] ram_waddr;
    logic [DIG_W-1:0]  ram_wdata;
    logic [DIG_AW-1:0] ram_raddr;
    logic [DIG_W-1:0]  ram_rdata;
    logic [DIG_W-1:0]  fold_digit;

    logic [X_W-1:0]    div_x;
    logic [Q_W-1:0]    div_q;
    logic [DIG_W-1:0]  div_r;

    // Digit store, least significant digit at address zero
    b58enc_ram #(
        .WIDTH (DIG_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    b58enc_div58 u_div (
        .x    (div_x),
        .quot (div_q),
        .rem  (div_r)
    );

    // Handshake and sequencing conditions
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign room          = (byte_count_reg < BYTE_W'(MAX_BYTES));
    assign fold_end      = ((CNT_W'(j_reg) + CNT_W'(1)) == digit_count_reg);
    assign ext_done      = (carry_reg == '0) || (digit_count_reg >= CNT_W'(MAX_DIGITS));
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Leading '1's: an all-zero message keeps one zero as its digit
    assign ones_calc  = zero_run_reg
                      - BYTE_W'(all_zero_reg && (zero_run_reg != '0));
    assign emit_state = (ones_calc != '0) ? ST_EMIT_ONE : ST_EMIT_RD;

    // First byte of a message sees an empty store
    assign fold_digit = fresh_reg ? '0 : ram_rdata;

    // Feed the shared divider
    always_comb begin
        if (state_reg == ST_FOLD) begin
            div_x = X_W'({fold_digit, 8'h00}) + X_W'(carry_reg);
        end else begin
            div_x = X_W'(carry_reg);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && room) begin
                    state_next = ST_FOLD;
                end else if (accept && s_axis_tlast) begin
                    state_next = emit_state;
                end
            end
            ST_FOLD: begin
                if (fold_end) begin
                    state_next = ST_EXT;
                end
            end
            ST_EXT: begin
                if (ext_done) begin
                    state_next = last_pend_reg ? emit_state : ST_IDLE;
                end
            end
            ST_EMIT_ONE: begin
                if (out_free && (ones_reg == BYTE_W'(1))) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    state_next = (dig_idx_reg == '0) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        carry_next       = carry_reg;
        j_next           = j_reg;
        digit_count_next = digit_count_reg;
        zero_run_next    = zero_run_reg;
        all_zero_next    = all_zero_reg;
        byte_count_next  = byte_count_reg;
        ovf_next         = ovf_reg;
        last_pend_next   = last_pend_reg;
        fresh_next       = fresh_reg;
        ones_next        = ones_reg;
        dig_idx_next     = dig_idx_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;
        m_user_next      = m_user_reg;
        ram_we           = 1'b0;
        ram_waddr        = j_reg;
        ram_wdata        = div_r;
        ram_raddr        = '0;

        case (state_reg)
            ST_IDLE: begin
                // Take a byte: fold it in, or drop it when full
                if (accept) begin
                    if (room) begin
                        byte_count_next = byte_count_reg + BYTE_W'(1);
                        if (all_zero_reg && (s_axis_tdata == 8'h00)) begin
                            zero_run_next = zero_run_reg + BYTE_W'(1);
                        end else begin
                            all_zero_next = 1'b0;
                        end
                        carry_next     = s_axis_tdata;
                        j_next         = '0;
                        fresh_next     = (byte_count_reg == '0);
                        last_pend_next = s_axis_tlast;
                    end else begin
                        ovf_next = 1'b1;
                        if (s_axis_tlast) begin
                            ones_next    = ones_calc;
                            dig_idx_next = DIG_AW'(digit_count_reg - CNT_W'(1));
                        end
                    end
                end
            end
            ST_FOLD: begin
                // Multiply one digit by 256, add carry, keep remainder
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                carry_next = div_q;
                if (fold_end) begin
                    ram_raddr = '0;
                end else begin
                    ram_raddr = j_reg + DIG_AW'(1);
                    j_next    = j_reg + DIG_AW'(1);
                end
            end
            ST_EXT: begin
                // Grow the digit count while carry is left
                if (ext_done) begin
                    if (carry_reg != '0) begin
                        ovf_next = 1'b1;
                    end
                    if (last_pend_reg) begin
                        ones_next    = ones_calc;
                        dig_idx_next = DIG_AW'(digit_count_reg - CNT_W'(1));
                    end
                end else begin
                    ram_we           = 1'b1;
                    ram_waddr        = DIG_AW'(digit_count_reg);
                    digit_count_next = digit_count_reg + CNT_W'(1);
                    carry_next       = div_q;
                end
            end
            ST_EMIT_ONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = b58_char('0);
                    m_last_next  = 1'b0;
                    m_user_next  = ovf_reg;
                    ones_next    = ones_reg - BYTE_W'(1);
                end
            end
            ST_EMIT_RD: begin
                ram_raddr = dig_idx_reg;
            end
            ST_EMIT_LD: begin
                // Hold the read address so the digit stays put during a stall
                ram_raddr = dig_idx_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = b58_char(ram_rdata);
                    m_last_next  = (dig_idx_reg == '0);
                    m_user_next  = ovf_reg;
                    if (dig_idx_reg == '0) begin
                        digit_count_next = CNT_W'(1);
                        zero_run_next    = '0;
                        all_zero_next    = 1'b1;
                        byte_count_next  = '0;
                        ovf_next         = 1'b0;
                    end else begin
                        dig_idx_next = dig_idx_reg - DIG_AW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            digit_count_reg <= CNT_W'(1);
            zero_run_reg    <= '0;
            all_zero_reg    <= 1'b1;
            byte_count_reg  <= '0;
            ovf_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            zero_run_reg    <= zero_run_next;
            all_zero_reg    <= all_zero_next;
            byte_count_reg  <= byte_count_next;
            ovf_reg         <= ovf_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        carry_reg     <= carry_next;
        j_reg         <= j_next;
        last_pend_reg <= last_pend_next;
        fresh_reg     <= fresh_next;
        ones_reg      <= ones_next;
        dig_idx_reg   <= dig_idx_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        m_user_reg    <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    // Checks on the sequencer
    `B58_ASSERT_ALWAYS(a_count_range, (digit_count_reg != '0) && (digit_count_reg <= CNT_W'(MAX_DIGITS)), "digit count out of range")
    `B58_ASSERT_IMPLY(a_fold_index, state_reg == ST_FOLD, CNT_W'(j_reg) < digit_count_reg, "fold index past digit count")
    `B58_ASSERT_ALWAYS(a_byte_bound, byte_count_reg <= BYTE_W'(MAX_BYTES), "byte count past capacity")
    `B58_ASSERT_NEXT(a_msg_clear, (state_reg == ST_EMIT_LD) && out_free && (dig_idx_reg == '0), (byte_count_reg == '0) && m_axis_tlast && m_axis_tvalid, "message not closed after final character")

endmodule
